// File: rtl/saa_pkg.sv
package saa_pkg;

    localparam int MAX_HOST_BITS = 10;
    localparam int ADDR_W        = 32;
    localparam int NODE_W        = MAX_HOST_BITS + 1;
    localparam int TREE_DEPTH    = 1 << NODE_W;
    localparam int CNT_W         = 11;
    localparam int HBITS_W       = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    localparam logic [HBITS_W-1:0] HBITS_MIN   = HBITS_W'(2);
    localparam logic [HBITS_W-1:0] HBITS_MAX   = HBITS_W'(MAX_HOST_BITS);
    localparam logic [HBITS_W-1:0] HBITS_RESET = HBITS_W'(8);

    localparam logic [CFG_IDX_W-1:0] REG_NETWORK   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HOST_BITS = CFG_IDX_W'(1);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_EXHAUSTED   = 2'd1,
        ST_RESERVED    = 2'd2,
        ST_DOUBLE_FREE = 2'd3
    } t_saa_status;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] address;
    } t_saa_in;

    typedef struct packed {
        t_saa_status       status;
        logic [ADDR_W-1:0] granted_address;
        logic [CNT_W-1:0]  free_count;
    } t_saa_out;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR_INIT,
        OP_CLEAR,
        OP_CAPTURE,
        OP_RD_LEAF,
        OP_RD_ROOT,
        OP_RD_LEFT,
        OP_DESCEND,
        OP_SET_LEAF,
        OP_RD_SIB,
        OP_UP,
        OP_FREE,
        OP_FINISH
    } t_saa_op;

    typedef struct packed {
        t_saa_op     op;
        t_saa_status status;
    } t_saa_cmd;

    typedef struct packed {
        logic rd_full;
        logic clr_last;
        logic lvl_last;
        logic at_root;
        logic addr_nz;
        logic host_rsv;
        logic is_free;
        logic cfg_hit;
    } t_saa_stat;

endpackage

// File: rtl/saa_datapath.sv
module saa_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [saa_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [saa_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  saa_pkg::t_saa_in                    i_item,
    input  saa_pkg::t_saa_cmd                   i_cmd,
    output saa_pkg::t_saa_stat                  o_stat,
    output saa_pkg::t_saa_out                   o_result
);

    localparam int NW = saa_pkg::NODE_W;

    logic                            mem [saa_pkg::TREE_DEPTH];
    logic                            r_rdata;

    logic [saa_pkg::ADDR_W-1:0]      r_net;
    logic [saa_pkg::HBITS_W-1:0]     r_hbits;
    logic                            r_cmd;
    logic [saa_pkg::ADDR_W-1:0]      r_addr;
    logic [NW-1:0]                   r_idx;
    logic                            r_val;
    logic [saa_pkg::HBITS_W-1:0]     r_lvl;
    logic [NW-1:0]                   r_clr;
    logic [saa_pkg::CNT_W-1:0]       r_used;
    logic [NW-1:0]                   r_host;
    saa_pkg::t_saa_status            r_status;
    logic [saa_pkg::ADDR_W-1:0]      r_granted;

    logic [saa_pkg::HBITS_W-1:0]     eff_bits;
    logic [NW-1:0]                   size;
    logic [NW-1:0]                   hmask;
    logic [NW-1:0]                   host;
    logic [NW-1:0]                   leaf;
    logic [NW-1:0]                   top_leaf;
    logic [NW-1:0]                   left;
    logic                            rd_en;
    logic [NW-1:0]                   rd_addr;
    logic                            wr_en;
    logic [NW-1:0]                   wr_addr;
    logic                            wr_data;
    logic                            up_val;

    always_comb begin
        if (r_hbits < saa_pkg::HBITS_MIN) begin
            eff_bits = saa_pkg::HBITS_MIN;
        end else if (r_hbits > saa_pkg::HBITS_MAX) begin
            eff_bits = saa_pkg::HBITS_MAX;
        end else begin
            eff_bits = r_hbits;
        end
    end

    assign size     = NW'(1) << eff_bits;
    assign hmask    = size - NW'(1);
    assign host     = r_addr[NW-1:0] & hmask;
    assign leaf     = size | host;
    assign top_leaf = NW'({size, 1'b0}) - NW'(1);
    assign left     = {r_idx[NW-2:0], 1'b0};
    assign up_val   = r_val & r_rdata;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = 1'b0;
        case (i_cmd.op)
            saa_pkg::OP_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = (r_clr == size) || (r_clr == top_leaf);
            end
            saa_pkg::OP_RD_LEAF: begin
                rd_en   = 1'b1;
                rd_addr = leaf;
            end
            saa_pkg::OP_RD_ROOT: begin
                rd_en   = 1'b1;
                rd_addr = NW'(1);
            end
            saa_pkg::OP_RD_LEFT: begin
                rd_en   = 1'b1;
                rd_addr = left;
            end
            saa_pkg::OP_RD_SIB: begin
                rd_en   = 1'b1;
                rd_addr = r_idx ^ NW'(1);
            end
            saa_pkg::OP_SET_LEAF: begin
                wr_en   = 1'b1;
                wr_data = 1'b1;
            end
            saa_pkg::OP_UP: begin
                wr_en   = 1'b1;
                wr_addr = r_idx >> 1;
                wr_data = up_val;
            end
            saa_pkg::OP_FREE: begin
                wr_en   = 1'b1;
                wr_data = 1'b0;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Full-bit tree, one bit per heap node.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net   <= '0;
            r_hbits <= saa_pkg::HBITS_RESET;
            r_clr   <= '0;
            r_used  <= saa_pkg::CNT_W'(2);
        end else begin
            if (i_cfg_we && i_cfg_idx == saa_pkg::REG_NETWORK) begin
                r_net <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == saa_pkg::REG_HOST_BITS) begin
                r_hbits <= i_cfg_data[saa_pkg::HBITS_W-1:0];
            end
            case (i_cmd.op)
                saa_pkg::OP_CLEAR_INIT: begin
                    r_clr  <= '0;
                    r_used <= saa_pkg::CNT_W'(2);
                end
                saa_pkg::OP_CLEAR: begin
                    r_clr <= r_clr + NW'(1);
                end
                saa_pkg::OP_SET_LEAF: begin
                    r_used <= r_used + saa_pkg::CNT_W'(1);
                end
                saa_pkg::OP_FINISH: begin
                    if (i_cmd.status == saa_pkg::ST_OK && r_cmd == saa_pkg::CMD_FREE
                        && r_used != '0) begin
                        r_used <= r_used - saa_pkg::CNT_W'(1);
                    end
                end
                default: begin
                    r_clr <= r_clr;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            saa_pkg::OP_CAPTURE: begin
                r_cmd  <= i_item.cmd;
                r_addr <= i_item.address;
            end
            saa_pkg::OP_RD_LEAF: begin
                r_idx <= leaf;
            end
            saa_pkg::OP_RD_ROOT: begin
                r_idx <= NW'(1);
                r_lvl <= '0;
            end
            saa_pkg::OP_DESCEND: begin
                r_idx <= left | NW'(r_rdata);
                r_lvl <= r_lvl + saa_pkg::HBITS_W'(1);
            end
            saa_pkg::OP_SET_LEAF: begin
                r_val  <= 1'b1;
                r_host <= r_idx & hmask;
            end
            saa_pkg::OP_UP: begin
                r_val <= up_val;
                r_idx <= r_idx >> 1;
            end
            saa_pkg::OP_FREE: begin
                r_idx <= r_idx >> 1;
            end
            saa_pkg::OP_FINISH: begin
                r_status <= i_cmd.status;
                if (i_cmd.status == saa_pkg::ST_OK && r_cmd == saa_pkg::CMD_ALLOC) begin
                    r_granted <= r_net | saa_pkg::ADDR_W'(r_host);
                end else begin
                    r_granted <= '0;
                end
            end
            default: begin
                r_val <= r_val;
            end
        endcase
    end

    assign o_stat.rd_full  = r_rdata;
    assign o_stat.clr_last = (r_clr == '1);
    assign o_stat.lvl_last = (r_lvl == eff_bits - saa_pkg::HBITS_W'(1));
    assign o_stat.at_root  = (r_idx == NW'(1));
    assign o_stat.addr_nz  = (r_addr != '0);
    assign o_stat.host_rsv = (host == '0) || (host == hmask);
    assign o_stat.is_free  = (r_cmd == saa_pkg::CMD_FREE);
    assign o_stat.cfg_hit  = i_cfg_we && (i_cfg_idx == saa_pkg::REG_NETWORK
                                          || i_cfg_idx == saa_pkg::REG_HOST_BITS);

    assign o_result.status          = r_status;
    assign o_result.granted_address = r_granted;
    assign o_result.free_count      = size - r_used;

endmodule

// File: rtl/saa_controller.sv
module saa_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  saa_pkg::t_saa_stat  i_stat,
    output saa_pkg::t_saa_cmd   o_cmd,
    output logic                o_busy,
    output logic                o_done
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_A_CHK,
        S_R_CHK,
        S_D_RD,
        S_D_CHK,
        S_SET,
        S_UP_RD,
        S_UP_WR,
        S_F_CHK,
        S_F_WR,
        S_F_END,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;

    always_comb begin
        n_state       = r_state;
        n_done        = 1'b0;
        o_cmd.op      = saa_pkg::OP_NONE;
        o_cmd.status  = saa_pkg::ST_OK;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = saa_pkg::OP_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = saa_pkg::OP_CAPTURE;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.is_free) begin
                    if (i_stat.host_rsv) begin
                        o_cmd.op     = saa_pkg::OP_FINISH;
                        o_cmd.status = saa_pkg::ST_RESERVED;
                        n_state      = S_DONE;
                    end else begin
                        o_cmd.op = saa_pkg::OP_RD_LEAF;
                        n_state  = S_F_CHK;
                    end
                end else if (i_stat.addr_nz) begin
                    o_cmd.op = saa_pkg::OP_RD_LEAF;
                    n_state  = S_A_CHK;
                end else begin
                    o_cmd.op = saa_pkg::OP_RD_ROOT;
                    n_state  = S_R_CHK;
                end
            end
            S_A_CHK: begin
                if (!i_stat.rd_full) begin
                    n_state = S_SET;
                end else begin
                    o_cmd.op = saa_pkg::OP_RD_ROOT;
                    n_state  = S_R_CHK;
                end
            end
            S_R_CHK: begin
                if (i_stat.rd_full) begin
                    o_cmd.op     = saa_pkg::OP_FINISH;
                    o_cmd.status = saa_pkg::ST_EXHAUSTED;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.op = saa_pkg::OP_RD_LEFT;
                    n_state  = S_D_CHK;
                end
            end
            S_D_RD: begin
                o_cmd.op = saa_pkg::OP_RD_LEFT;
                n_state  = S_D_CHK;
            end
            S_D_CHK: begin
                o_cmd.op = saa_pkg::OP_DESCEND;
                n_state  = i_stat.lvl_last ? S_SET : S_D_RD;
            end
            S_SET: begin
                o_cmd.op = saa_pkg::OP_SET_LEAF;
                n_state  = S_UP_RD;
            end
            S_UP_RD: begin
                if (i_stat.at_root) begin
                    o_cmd.op = saa_pkg::OP_FINISH;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = saa_pkg::OP_RD_SIB;
                    n_state  = S_UP_WR;
                end
            end
            S_UP_WR: begin
                o_cmd.op = saa_pkg::OP_UP;
                n_state  = S_UP_RD;
            end
            S_F_CHK: begin
                if (!i_stat.rd_full) begin
                    o_cmd.op     = saa_pkg::OP_FINISH;
                    o_cmd.status = saa_pkg::ST_DOUBLE_FREE;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_F_WR;
                end
            end
            S_F_WR: begin
                o_cmd.op = saa_pkg::OP_FREE;
                if (i_stat.at_root) begin
                    n_state = S_F_END;
                end
            end
            S_F_END: begin
                o_cmd.op = saa_pkg::OP_FINISH;
                n_state  = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        if (n_state == S_DONE) begin
            n_done = 1'b1;
        end
        // A write of either layout register restarts the clearing sweep.
        if (i_stat.cfg_hit) begin
            o_cmd.op     = saa_pkg::OP_CLEAR_INIT;
            o_cmd.status = saa_pkg::ST_OK;
            n_state      = S_CLEAR;
            n_done       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// File: rtl/subnet_address_allocator.sv
// Subnet host address allocator.
// A transaction is accepted at a rising edge where start is high and busy is
// low; i_item carries the command (allocate or free) and the address. Exactly
// one result follows: o_done is high for one cycle while o_result holds the
// status, the granted address and the count of free hosts. The receiver
// cannot stall, so the result must be taken in that cycle.
// Host usage is kept in a 2048-entry tree of full bits held in a single-port
// style memory (one read or one write per cycle), walked one level at a time.
// The shortest transaction is a free of a reserved host; the longest is an
// allocate whose requested host is used, followed by the lowest-free walk.
// The walk goes one tree level at a time, so the length grows with H, the
// effective number of host bits. Busy drops in the cycle after the result,
// so a new transaction is accepted only once the last one is through.
// After reset, and after every write of network_address or host_bits through
// the configuration port, the block runs a clearing pass over all 2048 words
// of the tree memory and marks the network and broadcast hosts used; busy
// stays high during the pass. Configuration must be written only while the
// block is idle or clearing; the block itself does not enforce this. A write
// during the pass restarts it.
module subnet_address_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  saa_pkg::t_saa_in                i_item,
    input  logic                            i_cfg_we,
    input  logic [saa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [saa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_done,
    output saa_pkg::t_saa_out               o_result
);

    saa_pkg::t_saa_cmd  ctrl_cmd;
    saa_pkg::t_saa_stat dp_stat;

    // The controller sequences the tree walk; the datapath owns the memory,
    // the configuration registers and the result registers.
    saa_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (ctrl_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    saa_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (ctrl_cmd),
        .o_stat     (dp_stat),
        .o_result   (o_result)
    );

`ifndef SYNTHESIS
    // A result is only produced while a transaction is in flight.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe outside a transaction");

    // Only a successful transaction carries a granted address.
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != saa_pkg::ST_OK) |-> (o_result.granted_address == '0))
        else $error("granted address on a failed transaction");

    // An accepted transaction keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cfg_we) |=> busy)
        else $error("accepted transaction did not raise busy");

    // Free count never exceeds the largest pool size.
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.free_count <= saa_pkg::CNT_W'(1024)))
        else $error("free count out of range");
`endif

endmodule

// File: test/tb_top.sv
module tb_top;
    import saa_pkg::*;

    // Clock and reset. Reset is synchronous and active low.
    logic i_clk;
    logic i_rst_n;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Stimulus and configuration ports of the block under test.
    logic                  start;
    logic                  busy;
    t_saa_in               i_item;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_done;
    t_saa_out              o_result;

    subnet_address_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    // Our own copy of the allocator state. The tree is heap indexed with the
    // root at 1; the leaf of host h sits at 2^H + h, where H is the effective
    // number of host bits.
    logic [31:0]      pool_network;
    logic [3:0]       pool_host_bits;
    logic             pool_tree [0:TREE_DEPTH-1];
    int unsigned      pool_used;

    // Items waiting to be driven and results the block still owes us.
    t_saa_in          pending_items [$];
    t_saa_out         owed_results [$];

    int unsigned      cycle_count;
    int unsigned      error_count;
    int unsigned      sent_count;
    int unsigned      checked_count;
    int unsigned      status_seen [4];
    int unsigned      config_count;
    int unsigned      sender_idle_pct;
    logic             item_in_flight;

    localparam int unsigned CYCLE_LIMIT = 1500000;

    // Effective number of host bits: out-of-range settings are clamped.
    function automatic int unsigned pool_bits();
        if (pool_host_bits < HBITS_MIN)
            return HBITS_MIN;
        if (pool_host_bits > HBITS_MAX)
            return HBITS_MAX;
        return pool_host_bits;
    endfunction

    // Clear the tree and mark the network and broadcast hosts as used.
    function automatic void pool_rebuild();
        int unsigned base;
        base = 1 << pool_bits();
        foreach (pool_tree[k])
            pool_tree[k] = 1'b0;
        pool_tree[base] = 1'b1;
        pool_tree[2 * base - 1] = 1'b1;
        pool_used = 2;
    endfunction

    // A node is full when both its children are full; refresh the path up.
    function automatic void pool_fix_path(int unsigned leaf);
        int unsigned idx;
        idx = leaf;
        while (idx > 1) begin
            idx = idx >> 1;
            pool_tree[idx] = pool_tree[2 * idx] && pool_tree[2 * idx + 1];
        end
    endfunction

    // Work out the one result that a transaction produces, updating the state.
    function automatic t_saa_out pool_apply(t_saa_in item);
        t_saa_out    res;
        int unsigned size;
        int unsigned hmask;
        int unsigned host;
        int unsigned leaf;
        int unsigned idx;
        size  = 1 << pool_bits();
        hmask = size - 1;
        host  = item.address & hmask;
        leaf  = size + host;
        res.status = ST_OK;
        res.granted_address = '0;
        if (item.cmd == CMD_ALLOC) begin
            if (item.address != 0 && !pool_tree[leaf]) begin
                // The requested host is free, so it is granted as asked.
                pool_tree[leaf] = 1'b1;
                pool_fix_path(leaf);
                pool_used++;
                res.granted_address = pool_network | host;
            end else if (pool_tree[1]) begin
                res.status = ST_EXHAUSTED;
            end else begin
                // Walk down to the lowest free host.
                idx = 1;
                for (int lvl = 0; lvl < pool_bits(); lvl++)
                    idx = pool_tree[2 * idx] ? 2 * idx + 1 : 2 * idx;
                pool_tree[idx] = 1'b1;
                pool_fix_path(idx);
                pool_used++;
                res.granted_address = pool_network | (idx - size);
            end
        end else begin
            if (host == 0 || host == hmask) begin
                res.status = ST_RESERVED;
            end else if (!pool_tree[leaf]) begin
                res.status = ST_DOUBLE_FREE;
            end else begin
                idx = leaf;
                while (idx >= 1) begin
                    pool_tree[idx] = 1'b0;
                    idx = idx >> 1;
                end
                if (pool_used > 0)
                    pool_used--;
            end
        end
        res.free_count = CNT_W'(size - pool_used);
        return res;
    endfunction

    // Driver: at each falling edge, offer the next item unless the sender
    // decides to idle. An item counts as taken at a rising edge where start is
    // high and busy is low, which the flag below records at that edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_in_flight <= 1'b0;
        end else begin
            item_in_flight <= start && !busy;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            // A transaction taken at the last rising edge leaves the queue now.
            if (item_in_flight && pending_items.size() > 0) begin
                owed_results.push_back(pool_apply(pending_items.pop_front()));
                sent_count++;
            end
            if (pending_items.size() > 0 &&
                $urandom_range(99) >= sender_idle_pct) begin
                start  <= 1'b1;
                i_item <= pending_items[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_saa_out want;
        if (i_rst_n && o_done) begin
            if (owed_results.size() == 0) begin
                $display("%0t: result with nothing expected: actual %p", $time, o_result);
                error_count++;
            end else begin
                want = owed_results.pop_front();
                checked_count++;
                status_seen[want.status]++;
                if (o_result.status !== want.status)
                    $display("%0t: status mismatch: expected %s actual %0d", $time,
                             want.status.name(), o_result.status);
                if (o_result.granted_address !== want.granted_address)
                    $display("%0t: granted_address mismatch: expected %h actual %h",
                             $time, want.granted_address, o_result.granted_address);
                if (o_result.free_count !== want.free_count)
                    $display("%0t: free_count mismatch: expected %0d actual %0d", $time,
                             want.free_count, o_result.free_count);
                if (o_result !== want)
                    error_count++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Wait until the queued items are all accepted and every result is back,
    // then let the clock run on before returning.
    task automatic drain();
        while (pending_items.size() > 0 || owed_results.size() > 0 || item_in_flight)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Registers are written at a falling edge, while the block is idle or clearing.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        config_count++;
        if (idx == REG_NETWORK) begin
            pool_network = value;
            pool_rebuild();
        end else if (idx == REG_HOST_BITS) begin
            pool_host_bits = value[3:0];
            pool_rebuild();
        end
    endtask

    function automatic void queue_item(logic cmd, logic [31:0] addr);
        t_saa_in item;
        item.cmd = cmd;
        item.address = addr;
        pending_items.push_back(item);
    endfunction

    // One random phase. Most of it allocates and frees hosts that are
    // in range for the current size, so the pool fills and drains; the rest asks
    // for the lowest free host or uses raw random addresses.
    task automatic random_phase(int unsigned count);
        int unsigned span;
        int unsigned host;
        logic [31:0] noise;
        span = 1 << pool_bits();
        for (int unsigned n = 0; n < count; n++) begin
            host  = $urandom_range(span - 1);
            noise = $urandom;
            case ($urandom_range(9))
                0, 1, 2, 3: queue_item(CMD_ALLOC, (noise & ~(span - 1)) | host);
                4:          queue_item(CMD_ALLOC, 32'd0);
                5, 6, 7:    queue_item(CMD_FREE, (noise & ~(span - 1)) | host);
                8:          queue_item(CMD_ALLOC, noise);
                default:    queue_item(CMD_FREE, noise);
            endcase
        end
        drain();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_item         = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        cycle_count    = 0;
        error_count    = 0;
        sent_count     = 0;
        checked_count  = 0;
        config_count   = 0;
        sender_idle_pct = 18;
        status_seen    = '{default: 0};
        pool_network   = '0;
        pool_host_bits = HBITS_RESET;
        pool_rebuild();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed transactions at reset settings (8 host bits): the reserved
        // hosts, a double free, a specific grant that ignores network bits, a
        // request for a used host that falls back to the lowest free one.
        queue_item(CMD_FREE, 32'h0000_0000);
        queue_item(CMD_FREE, 32'hFFFF_FFFF);
        queue_item(CMD_FREE, 32'h0000_0005);
        queue_item(CMD_ALLOC, 32'hABCD_EF05);
        queue_item(CMD_ALLOC, 32'h0000_0005);
        queue_item(CMD_ALLOC, 32'h0000_0000);
        queue_item(CMD_ALLOC, 32'hFFFF_FF00);
        queue_item(CMD_FREE, 32'h1234_5605);
        queue_item(CMD_FREE, 32'h0000_0005);
        queue_item(CMD_ALLOC, 32'h5555_55FE);
        drain();

        // Smallest pool, with an out-of-range host_bits that clamps to 2:
        // two usable hosts, then an exhausted pool.
        write_reg(REG_NETWORK, 32'hC0A8_0100);
        write_reg(REG_HOST_BITS, 32'h0000_0000);
        queue_item(CMD_ALLOC, 32'd0);
        queue_item(CMD_ALLOC, 32'd0);
        queue_item(CMD_ALLOC, 32'd2);
        queue_item(CMD_FREE, 32'd3);
        queue_item(CMD_FREE, 32'd1);
        queue_item(CMD_ALLOC, 32'hFFFF_FFFD);
        drain();
        // host_bits above the maximum clamps to 10; an index past the list
        // must change nothing.
        write_reg(REG_HOST_BITS, 32'hFFFF_FFFF);
        write_reg(2'd3, $urandom);
        queue_item(CMD_ALLOC, 32'h0000_03FE);
        queue_item(CMD_FREE, 32'h0000_03FF);
        queue_item(CMD_ALLOC, 32'd0);
        drain();

        // Random phases over a range of sizes, sender idle 18 percent.
        write_reg(REG_NETWORK, 32'hFFFF_FFFF);
        write_reg(REG_HOST_BITS, 32'd2);
        random_phase(150);
        write_reg(REG_NETWORK, $urandom);
        write_reg(REG_HOST_BITS, 32'd3);
        random_phase(250);
        write_reg(REG_HOST_BITS, 32'd5);
        random_phase(200);

        // Sender idle 47 percent.
        sender_idle_pct = 47;
        write_reg(REG_NETWORK, 32'h0000_0000);
        write_reg(REG_HOST_BITS, 32'd4);
        random_phase(300);
        write_reg(REG_HOST_BITS, $urandom_range(15));
        random_phase(200);

        // No idling at all.
        sender_idle_pct = 0;
        write_reg(REG_NETWORK, $urandom);
        write_reg(REG_HOST_BITS, 32'd2);
        random_phase(300);
        write_reg(REG_HOST_BITS, 32'd10);
        random_phase(250);
        write_reg(REG_HOST_BITS, 32'd6);
        random_phase(250);

        $display("Checked %0d of %0d transactions over %0d register writes.",
                 checked_count, sent_count, config_count);
        $display("Status mix: ok %0d, exhausted %0d, reserved %0d, double free %0d.",
                 status_seen[ST_OK], status_seen[ST_EXHAUSTED],
                 status_seen[ST_RESERVED], status_seen[ST_DOUBLE_FREE]);
        if (error_count == 0 && owed_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/saa_pkg.sv
rtl/saa_datapath.sv
rtl/saa_controller.sv
rtl/subnet_address_allocator.sv
test/tb_top.sv
